[sv/piecewise_linear_interpolator_macros.svh]
// Assertion macros shared by the interpolator RTL.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_MACROS_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PLI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/pli_pkg.sv]
// Package: widths, codes and types for the piecewise linear interpolator.
package pli_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int DATA_W      = 32;
	localparam int IDX_W       = 4;
	localparam int CFG_W       = 5;
	localparam int CNT_W       = ($clog2(TABLE_DEPTH + 1) > CFG_W) ?
	                             $clog2(TABLE_DEPTH + 1) : CFG_W;
	localparam int STEP_W      = $clog2(DATA_W);

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_BELOW = 2'd1,
		STATUS_ABOVE = 2'd2,
		STATUS_EMPTY = 2'd3
	} pli_status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RLAST,
		ST_RFIRST,
		ST_CHK0,
		ST_SCAN,
		ST_HIT,
		ST_RY0,
		ST_RY1,
		ST_DIV,
		ST_EMIT
	} pli_state_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_MUL,
		PH_DIV,
		PH_DONE
	} pli_div_phase_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] mag;
		logic [DATA_W-1:0] t;
		logic [DATA_W-1:0] d;
	} pli_div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quot;
	} pli_div_rsp_t;

endpackage

[sv/piecewise_linear_interpolator.sv]
// Piecewise linear interpolator over a breakpoint table held in two RAMs.
//
// Channels: in (valid/ready) carries write and query items; out (valid/ready)
// carries one result per query; cfg (valid/ready, always ready) sets
// point_count, to be written only while the block is idle.
// A write item stores one (x, y) pair; it gives no result.
// A query reads the last and first x, then scans x from index 1 one RAM read
// per cycle until it finds the first entry at or above query_x. A hit reads
// one y; otherwise two y reads feed a 32x32 multiply and a one-bit-per-cycle
// divider. An empty table goes straight to the emit state, and a query
// outside the span ends after the last and first x checks; otherwise the
// result waits on the scan, and for an interpolated one also on the divider.
// The scan and the serial divider set the rate: one item at a time, in_ready
// high only while idle. in_ready returns in the cycle that out_valid rises.
// The result sits in an output register, so the next item is taken while it
// waits; a stalled receiver holds the block only when a second result is
// done.
// Reset clears point_count and the control state; the table contents are
// undefined until written.
`include "piecewise_linear_interpolator_macros.svh"

module piecewise_linear_interpolator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pli_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               action,
	input  logic [pli_pkg::IDX_W-1:0]          entry_index,
	input  logic signed [pli_pkg::DATA_W-1:0]  point_x,
	input  logic signed [pli_pkg::DATA_W-1:0]  point_y,
	input  logic signed [pli_pkg::DATA_W-1:0]  query_x,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [pli_pkg::DATA_W-1:0]  result_y,
	output logic [1:0]                         status,
	output logic                               exact_hit
);
	import pli_pkg::*;

	pli_state_t state_q, state_d;

	logic [CFG_W-1:0]  point_count_q;
	logic [CNT_W-1:0]  cnt_in, cnt_q, last_idx;
	logic [ADDR_W-1:0] idx_q;
	logic [ADDR_W-1:0] x_raddr, y_raddr;
	logic [DATA_W-1:0] x_rd, y_rd;
	logic              mem_we, idx_ok;

	logic signed [DATA_W-1:0] q_q, xprev_q, x1_q, y0_q;
	logic                     above_q, neg_q;
	logic                     q_lt_x, q_gt_x, q_eq_x;

	logic signed [DATA_W:0]   dy;
	logic [DATA_W:0]          dy_abs;
	logic signed [DATA_W+1:0] sq, sum;
	logic [DATA_W-1:0]        sat_y;

	pli_div_req_t div_req;
	pli_div_rsp_t div_rsp;

	logic signed [DATA_W-1:0] res_y_q, out_y_q;
	pli_status_t              res_status_q, out_status_q;
	logic                     res_hit_q, out_hit_q, out_valid_q;
	logic                     emit_free;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign result_y  = out_y_q;
	assign status    = out_status_q;
	assign exact_hit = out_hit_q;

	assign cnt_in   = (CNT_W'(point_count_q) > CNT_W'(TABLE_DEPTH)) ?
	                  CNT_W'(TABLE_DEPTH) : CNT_W'(point_count_q);
	assign last_idx = cnt_q - CNT_W'(1);
	assign idx_ok   = CNT_W'(entry_index) < CNT_W'(TABLE_DEPTH);

	assign q_lt_x = q_q < $signed(x_rd);
	assign q_gt_x = q_q > $signed(x_rd);
	assign q_eq_x = q_q == $signed(x_rd);

	assign emit_free = !out_valid_q || out_ready;

	pli_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_x_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (ADDR_W'(entry_index)),
		.wdata (point_x),
		.raddr (x_raddr),
		.rdata (x_rd)
	);

	pli_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_y_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (ADDR_W'(entry_index)),
		.wdata (point_y),
		.raddr (y_raddr),
		.rdata (y_rd)
	);

	// Segment operands, formed while y1 comes out of the RAM.
	assign dy     = $signed({y_rd[DATA_W-1], y_rd}) - $signed({y0_q[DATA_W-1], y0_q});
	assign dy_abs = dy[DATA_W] ? (DATA_W+1)'(-dy) : dy;

	always_comb begin
		div_req.start = state_q == ST_RY1;
		div_req.mag   = dy_abs[DATA_W-1:0];
		div_req.t     = q_q - xprev_q;
		div_req.d     = x1_q - xprev_q;
	end

	pli_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Quotient is below 2^32, so y0 + signed quotient fits in 34 bits.
	assign sq    = neg_q ? -$signed({2'b00, div_rsp.quot}) : $signed({2'b00, div_rsp.quot});
	assign sum   = $signed({{2{y0_q[DATA_W-1]}}, y0_q}) + sq;
	assign sat_y = (sum[DATA_W+1:DATA_W-1] == 3'b000 || sum[DATA_W+1:DATA_W-1] == 3'b111) ?
	               sum[DATA_W-1:0] :
	               (sum[DATA_W+1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}});

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && action == ACT_QUERY) begin
					state_d = (cnt_in == '0) ? ST_EMIT : ST_RLAST;
				end
			end
			ST_RLAST:  state_d = ST_RFIRST;
			ST_RFIRST: state_d = ST_CHK0;
			ST_CHK0: begin
				if (q_lt_x || above_q) begin
					state_d = ST_EMIT;
				end else if (q_eq_x) begin
					state_d = ST_HIT;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!q_gt_x) begin
					state_d = q_eq_x ? ST_HIT : ST_RY0;
				end
			end
			ST_HIT: state_d = ST_EMIT;
			ST_RY0: state_d = ST_RY1;
			ST_RY1: state_d = ST_DIV;
			ST_DIV: if (div_rsp.done) state_d = ST_EMIT;
			ST_EMIT: if (emit_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		mem_we   = 1'b0;
		x_raddr  = '0;
		y_raddr  = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				mem_we   = in_valid && action == ACT_WRITE && idx_ok;
			end
			ST_RLAST:  x_raddr = last_idx[ADDR_W-1:0];
			ST_RFIRST: x_raddr = '0;
			ST_CHK0:   x_raddr = ADDR_W'(1);
			ST_SCAN: begin
				// read ahead the next x; y address serves a hit or the left end
				x_raddr = idx_q + ADDR_W'(1);
				y_raddr = q_eq_x ? idx_q : idx_q - ADDR_W'(1);
			end
			ST_RY0:  y_raddr = idx_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			point_count_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				point_count_q <= cfg_data;
			end
			if (state_q == ST_EMIT && emit_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid && action == ACT_QUERY) begin
					q_q          <= query_x;
					cnt_q        <= cnt_in;
					res_y_q      <= '0;
					res_status_q <= STATUS_EMPTY;
					res_hit_q    <= 1'b0;
				end
			end
			ST_RFIRST: above_q <= q_gt_x;
			ST_CHK0: begin
				if (q_lt_x) begin
					res_status_q <= STATUS_BELOW;
				end else if (above_q) begin
					res_status_q <= STATUS_ABOVE;
				end
				xprev_q <= x_rd;
				idx_q   <= ADDR_W'(1);
			end
			ST_SCAN: begin
				if (q_gt_x) begin
					xprev_q <= x_rd;
					idx_q   <= idx_q + ADDR_W'(1);
				end else begin
					x1_q <= x_rd;
				end
			end
			ST_HIT: begin
				res_y_q      <= y_rd;
				res_status_q <= STATUS_OK;
				res_hit_q    <= 1'b1;
			end
			ST_RY0: y0_q <= y_rd;
			ST_RY1: neg_q <= dy[DATA_W];
			ST_DIV: begin
				if (div_rsp.done) begin
					res_y_q      <= sat_y;
					res_status_q <= STATUS_OK;
					res_hit_q    <= 1'b0;
				end
			end
			ST_EMIT: begin
				if (emit_free) begin
					out_y_q      <= res_y_q;
					out_status_q <= res_status_q;
					out_hit_q    <= res_hit_q;
				end
			end
			default: ;
		endcase
	end

	`PLI_ASSERT_NEXT(a_write_no_result, clk, arst_n, in_valid && in_ready && action == ACT_WRITE, state_q == ST_IDLE, "write item left the idle state")
	`PLI_ASSERT_SAME(a_div_done_in_div, clk, arst_n, div_rsp.done, state_q == ST_DIV, "divider finished outside the divide state")
	`PLI_ASSERT_SAME(a_result_from_emit, clk, arst_n, $rose(out_valid_q), $past(state_q) == ST_EMIT, "result shown without passing the emit state")
	`PLI_ASSERT_NEXT(a_emit_completes, clk, arst_n, state_q == ST_EMIT && emit_free, out_valid_q && state_q == ST_IDLE, "emit with a free slot did not deliver the item")

endmodule

[sv/pli_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pli_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[sv/pli_muldiv.sv]
// Multiply then bit-serial restoring divide: quot = (mag * t) / d, with t < d.
module pli_muldiv (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pli_pkg::pli_div_req_t req,
	output pli_pkg::pli_div_rsp_t rsp
);
	import pli_pkg::*;

	pli_div_phase_t    phase_q, phase_d;
	logic [STEP_W-1:0] step_q;
	logic [DATA_W-1:0] a_q, b_q, div_q;
	logic [DATA_W-1:0] rem_q, low_q;
	logic [2*DATA_W-1:0] prod;
	logic [DATA_W:0]   trial;
	logic              fits;
	logic              last_step;

	assign prod      = a_q * b_q;
	assign trial     = {rem_q, low_q[DATA_W-1]};
	assign fits      = trial >= {1'b0, div_q};
	assign last_step = step_q == STEP_W'(DATA_W - 1);

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_IDLE: if (req.start) phase_d = PH_MUL;
			PH_MUL:  phase_d = PH_DIV;
			PH_DIV:  if (last_step) phase_d = PH_DONE;
			PH_DONE: phase_d = PH_IDLE;
			default: phase_d = PH_IDLE;
		endcase
	end

	always_comb begin
		rsp.done = phase_q == PH_DONE;
		rsp.quot = low_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			step_q  <= '0;
		end else begin
			phase_q <= phase_d;
			if (phase_q == PH_MUL) begin
				step_q <= '0;
			end else if (phase_q == PH_DIV) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	// Quotient bits shift into low_q as the low dividend bits shift out.
	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (req.start) begin
					a_q   <= req.mag;
					b_q   <= req.t;
					div_q <= req.d;
				end
			end
			PH_MUL: begin
				rem_q <= prod[2*DATA_W-1:DATA_W];
				low_q <= prod[DATA_W-1:0];
			end
			PH_DIV: begin
				if (fits) begin
					rem_q <= DATA_W'(trial - {1'b0, div_q});
				end else begin
					rem_q <= trial[DATA_W-1:0];
				end
				low_q <= {low_q[DATA_W-2:0], fits};
			end
			default: ;
		endcase
	end

endmodule
